@@ rtl/core/phc_pkg.sv @@
// Shared types, constants and codes of the packet header checker.
package phc_pkg;

   localparam int HEADER_BYTES = 40;
   localparam int CRC_FIELD_AT = 36;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [16:0] COUNT_LIMIT     = 17'h10000;
   localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
   localparam logic [31:0] MAGIC_RESET     = 32'h53574C4B;
   localparam logic [7:0]  VERSION_RESET   = 8'd1;
   localparam logic [63:0] TYPE_MASK_RESET = 64'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAGIC     = 2'd0,
      CSR_VERSION   = 2'd1,
      CSR_TYPE_MASK = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SHORT      = 3'd1,
      ST_MAGIC      = 3'd2,
      ST_VERSION    = 3'd3,
      ST_TYPE       = 3'd4,
      ST_HDR_LEN    = 3'd5,
      ST_LEN_MISMATCH = 3'd6,
      ST_CRC        = 3'd7
   } status_type;

   typedef struct packed {
      logic [31:0] magic;
      logic [7:0]  version;
      logic [63:0] type_mask;
   } cfg_type;

   typedef struct packed {
      logic [31:0] magic;
      logic [7:0]  version;
      logic [7:0]  kind;
      logic [15:0] hdr_len;
      logic [63:0] session;
      logic [31:0] seq_num;
      logic [31:0] ack;
      logic [63:0] offset;
      logic [15:0] payload;
      logic [15:0] flags;
      logic [31:0] crc_field;
   } hdr_type;

   typedef struct packed {
      hdr_type     hdr;
      logic [16:0] total;
      logic [31:0] crc;
   } rec_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  kind;
      logic [63:0] session;
      logic [31:0] seq_num;
      logic [31:0] ack;
      logic [63:0] offset;
      logic [15:0] payload;
      logic [15:0] flags;
   } result_type;

endpackage

@@ rtl/core/phc_if.sv @@
// Channel interfaces of the packet header checker: byte input, verdict output, register writes.
interface phc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface phc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  packet_kind;
   logic [63:0] session_value;
   logic [31:0] sequence_value;
   logic [31:0] ack_value;
   logic [63:0] stream_offset;
   logic [15:0] payload_count;
   logic [15:0] flag_bits;

   modport source (output valid, output status, output packet_kind, output session_value,
                   output sequence_value, output ack_value, output stream_offset,
                   output payload_count, output flag_bits, input ready);
   modport sink   (input valid, input status, input packet_kind, input session_value,
                   input sequence_value, input ack_value, input stream_offset,
                   input payload_count, input flag_bits, output ready);
endinterface

interface phc_csr_if import phc_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [63:0]            data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/phc_csr.sv @@
// Configuration registers of the packet header checker.
module phc_csr import phc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   phc_csr_if.sink   csr,
   output cfg_type   cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_MAGIC:     cfg_in.magic     = csr.data[31:0];
            CSR_VERSION:   cfg_in.version   = csr.data[7:0];
            CSR_TYPE_MASK: cfg_in.type_mask = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic     <= MAGIC_RESET;
         cfg_ff.version   <= VERSION_RESET;
         cfg_ff.type_mask <= TYPE_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/phc_front.sv @@
// Front end: takes bytes, runs the CRC and byte count, captures header fields.
module phc_front import phc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   phc_req_if.sink  req,
   input  logic     q_full,
   output logic     push,
   output rec_type  push_rec
);

   logic [16:0] count_ff, count_in;
   logic [31:0] crc_ff, crc_in;
   hdr_type     hdr_ff, hdr_in;
   logic        accept;
   logic        in_header;
   logic        crc_zero;
   logic [5:0]  pos;
   logic [31:0] crc_step;
   logic [16:0] total;

   // One byte through the reflected CRC-32, bit by bit.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign in_header = count_ff < 17'(HEADER_BYTES);
   assign pos       = count_ff[5:0];
   // The checksum bytes themselves enter the CRC as zeros.
   assign crc_zero  = in_header && (pos >= 6'(CRC_FIELD_AT));
   assign crc_step  = crc32_byte(crc_ff, crc_zero ? 8'h00 : req.data_byte);
   assign total     = (count_ff == COUNT_LIMIT) ? count_ff : count_ff + 17'd1;

   always_comb begin
      hdr_in = hdr_ff;
      if (accept && in_header) begin
         // Multi-byte fields arrive most significant byte first, so they shift in.
         unique case (pos) inside
            [6'd0:6'd3]:   hdr_in.magic     = {hdr_ff.magic[23:0], req.data_byte};
            6'd4:          hdr_in.version   = req.data_byte;
            6'd5:          hdr_in.kind      = req.data_byte;
            [6'd6:6'd7]:   hdr_in.hdr_len   = {hdr_ff.hdr_len[7:0], req.data_byte};
            [6'd8:6'd15]:  hdr_in.session   = {hdr_ff.session[55:0], req.data_byte};
            [6'd16:6'd19]: hdr_in.seq_num   = {hdr_ff.seq_num[23:0], req.data_byte};
            [6'd20:6'd23]: hdr_in.ack       = {hdr_ff.ack[23:0], req.data_byte};
            [6'd24:6'd31]: hdr_in.offset    = {hdr_ff.offset[55:0], req.data_byte};
            [6'd32:6'd33]: hdr_in.payload   = {hdr_ff.payload[7:0], req.data_byte};
            [6'd34:6'd35]: hdr_in.flags     = {hdr_ff.flags[7:0], req.data_byte};
            [6'd36:6'd39]: hdr_in.crc_field = {hdr_ff.crc_field[23:0], req.data_byte};
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      if (accept) begin
         if (req.last_byte) begin
            count_in = '0;
            crc_in   = CRC_INIT;
         end else begin
            count_in = total;
            crc_in   = crc_step;
         end
      end
   end

   assign push           = accept && req.last_byte;
   assign push_rec.hdr   = hdr_in;
   assign push_rec.total = total;
   assign push_rec.crc   = ~crc_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      push |=> (count_ff == '0 && crc_ff == CRC_INIT))
      else $error("datagram state not cleared after the last byte");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("byte count passed its saturation limit");

endmodule

@@ rtl/core/phc_queue.sv @@
// Short queue of finished datagram records between the front and back ends.
module phc_queue import phc_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output rec_type head_rec
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rec_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = cnt_ff == CNT_W'(DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_rec   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("record pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("record popped from an empty queue");

endmodule

@@ rtl/core/phc_back.sv @@
// Back end: checks one datagram record in order and holds the verdict for the receiver.
module phc_back import phc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  rec_type   head_rec,
   input  cfg_type   cfg,
   output logic      pop,
   phc_rsp_if.source rsp
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type out_ff, out_in;
   result_type res;
   status_type status;
   logic       type_ok;
   logic       len_bad;

   assign type_ok = (head_rec.hdr.kind[7:6] == 2'b00) && cfg.type_mask[head_rec.hdr.kind[5:0]];
   // A saturated count is always treated as a payload length mismatch.
   assign len_bad = head_rec.total[16]
                 || ((head_rec.total[15:0] - 16'(HEADER_BYTES)) != head_rec.hdr.payload);

   always_comb begin
      if (head_rec.total < 17'(HEADER_BYTES)) begin
         status = ST_SHORT;
      end else if (head_rec.hdr.magic != cfg.magic) begin
         status = ST_MAGIC;
      end else if (head_rec.hdr.version != cfg.version) begin
         status = ST_VERSION;
      end else if (!type_ok) begin
         status = ST_TYPE;
      end else if (head_rec.hdr.hdr_len != 16'(HEADER_BYTES)) begin
         status = ST_HDR_LEN;
      end else if (len_bad) begin
         status = ST_LEN_MISMATCH;
      end else if (head_rec.crc != head_rec.hdr.crc_field) begin
         status = ST_CRC;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      res = '0;
      res.status = status;
      if (status == ST_OK) begin
         res.kind    = head_rec.hdr.kind;
         res.session = head_rec.hdr.session;
         res.seq_num = head_rec.hdr.seq_num;
         res.ack     = head_rec.hdr.ack;
         res.offset  = head_rec.hdr.offset;
         res.payload = head_rec.hdr.payload;
         res.flags   = head_rec.hdr.flags;
      end
   end

   assign pop = head_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      out_in       = pop ? res : out_ff;
      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = out_ff.status;
   assign rsp.packet_kind    = out_ff.kind;
   assign rsp.session_value  = out_ff.session;
   assign rsp.sequence_value = out_ff.seq_num;
   assign rsp.ack_value      = out_ff.ack;
   assign rsp.stream_offset  = out_ff.offset;
   assign rsp.payload_count  = out_ff.payload;
   assign rsp.flag_bits      = out_ff.flags;

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ff.status != ST_OK) |->
         (out_ff.kind == '0 && out_ff.session == '0 && out_ff.seq_num == '0
          && out_ff.ack == '0 && out_ff.offset == '0 && out_ff.payload == '0
          && out_ff.flags == '0))
      else $error("failed verdict carries nonzero header fields");

endmodule

@@ rtl/core/packet_header_checker.sv @@
// Top level of the packet header checker: byte input, verdict output, configuration port.
//
// The req_if channel takes one datagram byte per item, with last_byte set on
// the final byte. The first 40 bytes are decoded as a big-endian header and
// every byte runs through a reflected CRC-32, the checksum bytes at offsets
// 36 to 39 counting as zeros. For each datagram the rsp_if channel gives one
// item: a status code and, when the status is OK, the decoded header fields
// (all zero otherwise). The csr_if channel writes the expected magic word,
// the expected version and the allowed type mask; it is always ready and
// should only be written while no datagram is in flight.
// Throughput is one byte per cycle with no gaps between datagrams while the
// queue is not full. After the last byte is accepted, the record is written
// into the record queue; once the output register is free, the check stage
// result is registered there and shown on rsp_if.
// When the receiver stalls, the output register holds its item and up to
// QUEUE_DEPTH further verdicts collect in the queue; bytes keep flowing
// until the queue is full, then req_if.ready drops.
// Reset clears the byte count, loads the CRC with all ones, empties the
// queue and restores the configuration registers to their defaults.
module packet_header_checker import phc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   phc_req_if.sink    req_if,
   phc_rsp_if.source  rsp_if,
   phc_csr_if.sink    csr_if
);

   cfg_type cfg;
   logic    q_full;
   logic    push;
   rec_type push_rec;
   logic    pop;
   logic    head_valid;
   rec_type head_rec;

   // Configuration registers.
   phc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_if),
      .cfg   (cfg)
   );

   // The front end hands one record per datagram to the queue on its last byte.
   phc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .q_full   (q_full),
      .push     (push),
      .push_rec (push_rec)
   );

   // The queue lets the byte stream run on while the receiver holds a verdict.
   phc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   // The back end runs the checks in order and registers the verdict.
   phc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .cfg        (cfg),
      .pop        (pop),
      .rsp        (rsp_if)
   );

endmodule

@@ tb/tb_packet_header_checker.sv @@
// Testbench of the packet header checker: verdict scoreboard, byte driver and datagram stimulus.
`timescale 1ns / 1ps

module tb_packet_header_checker;
   import phc_pkg::*;

   // Idle share of each side, in cycles per hundred.
   localparam int IDLE_PCT          = 22;
   // Length of the long receiver hold-off that fills the verdict queue.
   localparam int HOLD_CYCLES       = 300;
   // Cycles allowed for the check stage to drain before a register write.
   localparam int SETTLE_CYCLES     = 8;
   // The random part stops once both of these are reached.
   localparam int RANDOM_BYTES      = 680;
   localparam int MIN_RANDOM_FRAMES = 12;
   localparam int DRAIN_LIMIT       = 200000;

   // Ways in which a well-formed datagram is damaged before it is sent.
   typedef enum int {
      SPOIL_MAGIC,
      SPOIL_VERSION,
      SPOIL_KIND,
      SPOIL_HDR_LEN,
      SPOIL_PAY_LEN,
      SPOIL_CRC,
      SPOIL_TRUNCATE,
      SPOIL_COUNT
   } spoil_type;

   // One byte step of the reflected CRC-32.
   function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // The scoreboard keeps its own copy of the header, the CRC, the byte count and the
   // registers. Every accepted byte is stepped through it, and the last byte of a
   // datagram leaves one expected verdict in the queue.
   class verdict_predictor_type;
      logic [31:0] magic;
      logic [7:0]  version;
      logic [63:0] type_mask;
      logic [7:0]  hdr_bytes [HEADER_BYTES];
      logic [31:0] crc_acc;
      logic [16:0] count;
      result_type  pending_verdicts [$];
      int          mismatches;
      int          compared;

      function new();
         magic      = MAGIC_RESET;
         version    = VERSION_RESET;
         type_mask  = TYPE_MASK_RESET;
         crc_acc    = CRC_INIT;
         count      = '0;
         mismatches = 0;
         compared   = 0;
         foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
      endfunction

      function void set_register(csr_index_type idx, logic [63:0] value);
         case (idx)
            CSR_MAGIC:     magic     = value[31:0];
            CSR_VERSION:   version   = value[7:0];
            CSR_TYPE_MASK: type_mask = value;
            default: ;
         endcase
      endfunction

      function logic [63:0] be_field(int at, int len);
         logic [63:0] v;
         v = '0;
         for (int i = 0; i < len; i++) begin
            v = {v[55:0], hdr_bytes[6'(at + i)]};
         end
         return v;
      endfunction

      function void take_byte(logic [7:0] b, logic last);
         logic [7:0] crc_in;
         logic [7:0] kind;
         result_type verdict;
         status_type st;
         int         total;
         if (count < HEADER_BYTES) hdr_bytes[count[5:0]] = b;
         crc_in  = (count >= CRC_FIELD_AT && count < CRC_FIELD_AT + 4) ? 8'h00 : b;
         crc_acc = crc32_step(crc_acc, crc_in);
         if (count < COUNT_LIMIT) count++;
         if (!last) return;

         total = int'(count);
         kind  = hdr_bytes[5];
         if (total < HEADER_BYTES) begin
            st = ST_SHORT;
         end else if (be_field(0, 4) != {32'h0, magic}) begin
            st = ST_MAGIC;
         end else if (hdr_bytes[4] != version) begin
            st = ST_VERSION;
         end else if (kind > 8'd63 || !type_mask[kind[5:0]]) begin
            st = ST_TYPE;
         end else if (be_field(6, 2) != HEADER_BYTES) begin
            st = ST_HDR_LEN;
         end else if (total >= COUNT_LIMIT || (total - HEADER_BYTES) != be_field(32, 2)) begin
            // A saturated count is always treated as a length mismatch.
            st = ST_LEN_MISMATCH;
         end else if ((crc_acc ^ 32'hFFFFFFFF) != be_field(CRC_FIELD_AT, 4)) begin
            st = ST_CRC;
         end else begin
            st = ST_OK;
         end

         verdict        = '0;
         verdict.status = st;
         if (st == ST_OK) begin
            verdict.kind    = kind;
            verdict.session = be_field(8, 8);
            verdict.seq_num = 32'(be_field(16, 4));
            verdict.ack     = 32'(be_field(20, 4));
            verdict.offset  = be_field(24, 8);
            verdict.payload = 16'(be_field(32, 2));
            verdict.flags   = 16'(be_field(34, 2));
         end
         pending_verdicts.push_back(verdict);
         crc_acc = CRC_INIT;
         count   = '0;
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Mismatch in verdict %0d, %s: expected %h, got %h",
                        compared, name, want, got);
            end
         end
      endfunction

      function void match_verdict(result_type got);
         result_type want;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Verdict with no datagram behind it: status %0d", got.status);
            end
            return;
         end
         want = pending_verdicts.pop_front();
         check_field("status", 64'(want.status), 64'(got.status));
         check_field("packet_kind", 64'(want.kind), 64'(got.kind));
         check_field("session_value", want.session, got.session);
         check_field("sequence_value", 64'(want.seq_num), 64'(got.seq_num));
         check_field("ack_value", 64'(want.ack), 64'(got.ack));
         check_field("stream_offset", want.offset, got.offset);
         check_field("payload_count", 64'(want.payload), 64'(got.payload));
         check_field("flag_bits", 64'(want.flags), 64'(got.flags));
         compared++;
      endfunction
   endclass

   logic clock;
   logic reset;

   phc_req_if req_ch ();
   phc_rsp_if rsp_ch ();
   phc_csr_if csr_ch ();

   packet_header_checker i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   verdict_predictor_type board;
   result_type            rsp_item;

   // Datagram being assembled before it is sent.
   logic [7:0] frame [$];

   int bytes_offered = 0;
   // The main process raises hold_request to start one long receiver stall.
   bit hold_request  = 1'b0;
   // While set, the sender or the receiver does not idle at all.
   bit send_calm     = 1'b0;
   bit recv_calm     = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Sample both handshakes on the clock edge. Values read here are the ones that were
   // stable before the edge, since every driver uses nonblocking assignments.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            board.take_byte(req_ch.data_byte, req_ch.last_byte);
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            rsp_item.status  = status_type'(rsp_ch.status);
            rsp_item.kind    = rsp_ch.packet_kind;
            rsp_item.session = rsp_ch.session_value;
            rsp_item.seq_num = rsp_ch.sequence_value;
            rsp_item.ack     = rsp_ch.ack_value;
            rsp_item.offset  = rsp_ch.stream_offset;
            rsp_item.payload = rsp_ch.payload_count;
            rsp_item.flags   = rsp_ch.flag_bits;
            board.match_verdict(rsp_item);
         end
      end
   end

   // Receiver: random back-pressure, calm stretches, and one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         end
         rsp_ch.ready <= recv_calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Offer one byte and wait for it to be taken. The task is entered and left on a
   // rising edge, so valid gets exactly one assignment per time step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!send_calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bytes_offered++;
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) begin
         send_byte(frame[i], i == frame.size() - 1);
      end
   endtask

   // The extra edge in stop_sending lets the monitor note the last byte before the
   // queue of expected verdicts is looked at.
   task automatic wait_drained();
      stop_sending();
      while (board.pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [63:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      board.set_register(idx, value);
      @(posedge clock);
   endtask

   // fill selects the header field contents: 0 random, 1 all zeros, 2 all ones.
   function automatic logic [7:0] fill_byte(int fill);
      if (fill == 1) return 8'h00;
      if (fill == 2) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // The checksum covers the whole datagram with its own four bytes taken as zeros.
   function automatic void seal_crc();
      logic [31:0] c;
      if (frame.size() < HEADER_BYTES) return;
      c = CRC_INIT;
      for (int i = 0; i < frame.size(); i++) begin
         c = crc32_step(c, (i >= CRC_FIELD_AT && i < CRC_FIELD_AT + 4) ? 8'h00 : frame[i]);
      end
      c = c ^ 32'hFFFFFFFF;
      frame[CRC_FIELD_AT]     = c[31:24];
      frame[CRC_FIELD_AT + 1] = c[23:16];
      frame[CRC_FIELD_AT + 2] = c[15:8];
      frame[CRC_FIELD_AT + 3] = c[7:0];
   endfunction

   // A datagram that passes every check under the current register values, provided that kind is an allowed type.
   function automatic void build_frame(logic [7:0] kind, int pay_len, int fill);
      logic [15:0] hdr_len;
      logic [15:0] pay_field;
      hdr_len   = 16'(HEADER_BYTES);
      pay_field = 16'(pay_len);
      frame.delete();
      for (int i = 3; i >= 0; i--) frame.push_back(board.magic[8*i +: 8]);
      frame.push_back(board.version);
      frame.push_back(kind);
      frame.push_back(hdr_len[15:8]);
      frame.push_back(hdr_len[7:0]);
      repeat (24) frame.push_back(fill_byte(fill));
      frame.push_back(pay_field[15:8]);
      frame.push_back(pay_field[7:0]);
      repeat (2) frame.push_back(fill_byte(fill));
      repeat (4) frame.push_back(8'h00);
      repeat (pay_len) frame.push_back(8'($urandom_range(255)));
      seal_crc();
   endfunction

   function automatic void spoil_frame(spoil_type how);
      logic [7:0] flip;
      int         at;
      int         keep;
      flip = 8'h01 << $urandom_range(7);
      case (how)
         SPOIL_MAGIC: begin
            at = $urandom_range(0, 3);
            frame[at] = frame[at] ^ flip;
            seal_crc();
         end
         SPOIL_VERSION: begin
            frame[4] = frame[4] ^ flip;
            seal_crc();
         end
         SPOIL_KIND: begin
            // Either a type above 63 or any low type, which may be masked off.
            frame[5] = $urandom_range(1) ? 8'($urandom_range(64, 255))
                                         : 8'($urandom_range(63));
            seal_crc();
         end
         SPOIL_HDR_LEN: begin
            at = $urandom_range(6, 7);
            frame[at] = frame[at] ^ flip;
            seal_crc();
         end
         SPOIL_PAY_LEN: begin
            at = $urandom_range(32, 33);
            frame[at] = frame[at] ^ flip;
            seal_crc();
         end
         SPOIL_CRC: begin
            // Damage either the checksum itself or a payload byte after sealing.
            if (frame.size() > HEADER_BYTES && $urandom_range(1)) begin
               at = $urandom_range(HEADER_BYTES, frame.size() - 1);
            end else begin
               at = $urandom_range(CRC_FIELD_AT, CRC_FIELD_AT + 3);
            end
            frame[at] = frame[at] ^ flip;
         end
         SPOIL_TRUNCATE: begin
            keep  = $urandom_range(1, HEADER_BYTES - 1);
            frame = frame[0:keep-1];
         end
         default: ;
      endcase
   endfunction

   // Random bytes; some start with the right magic and version to get further in.
   function automatic void noise_frame();
      int len;
      len = $urandom_range(1, 70);
      frame.delete();
      repeat (len) frame.push_back(8'($urandom_range(255)));
      if (len >= 5 && $urandom_range(99) < 30) begin
         for (int i = 0; i < 4; i++) frame[i] = board.magic[8*(3-i) +: 8];
         frame[4] = board.version;
      end
   endfunction

   function automatic logic [7:0] pick_kind();
      logic [7:0] k;
      if (board.type_mask == '0) return 8'($urandom_range(255));
      repeat (64) begin
         k = 8'($urandom_range(63));
         if (board.type_mask[k[5:0]]) return k;
      end
      for (int i = 0; i < 64; i++) begin
         if (board.type_mask[6'(i)]) return 8'(i);
      end
      return 8'h00;
   endfunction

   // Rewrite one register, with the extremes chosen now and then.
   task automatic retune();
      csr_index_type idx;
      logic [63:0]   value;
      int            pick;
      idx  = csr_index_type'($urandom_range(0, 2));
      pick = $urandom_range(0, 3);
      case (idx)
         CSR_MAGIC: begin
            value = (pick == 0) ? 64'h0 :
                    (pick == 1) ? 64'hFFFF_FFFF : {32'h0, 32'($urandom)};
         end
         CSR_VERSION: begin
            value = (pick == 0) ? 64'h0 : (pick == 1) ? 64'hFF : 64'($urandom_range(255));
         end
         default: begin
            value = (pick == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                    (pick == 1) ? (64'h1 << $urandom_range(63)) : {32'($urandom), 32'($urandom)};
         end
      endcase
      write_register(idx, value);
   endtask

   initial begin
      int random_start;
      int frames;
      int waited;
      int roll;

      board = new();
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.last_byte <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_MAGIC;
      csr_ch.data      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values. The first datagram is a full
      // header so that no header byte is ever read before it has been written.
      build_frame(8'd0, 0, 1);
      send_frame();
      build_frame(8'd7, 3, 2);
      send_frame();
      // One byte short of a header, then a datagram of a single byte.
      build_frame(8'd3, 5, 0);
      frame = frame[0:HEADER_BYTES-2];
      send_frame();
      frame = {8'hFF};
      send_frame();
      build_frame(8'd1, 2, 0);
      spoil_frame(SPOIL_MAGIC);
      send_frame();
      build_frame(8'd1, 2, 0);
      spoil_frame(SPOIL_VERSION);
      send_frame();
      // A type whose mask bit is clear, one above 63 and the largest one.
      build_frame(8'd8, 1, 0);
      send_frame();
      build_frame(8'd64, 1, 0);
      send_frame();
      build_frame(8'd255, 1, 0);
      send_frame();
      build_frame(8'd2, 4, 0);
      spoil_frame(SPOIL_HDR_LEN);
      send_frame();
      build_frame(8'd2, 4, 0);
      spoil_frame(SPOIL_PAY_LEN);
      send_frame();
      build_frame(8'd2, 0, 0);
      frame[CRC_FIELD_AT + 3] = frame[CRC_FIELD_AT + 3] ^ 8'h80;
      send_frame();
      build_frame(8'd2, 6, 0);
      frame[HEADER_BYTES] = frame[HEADER_BYTES] ^ 8'h01;
      send_frame();
      frame.delete();
      repeat (HEADER_BYTES) frame.push_back(8'h00);
      send_frame();

      // Low extremes of magic and version with every type allowed.
      settle();
      write_register(CSR_MAGIC, 64'h0);
      write_register(CSR_VERSION, 64'h0);
      write_register(CSR_TYPE_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
      build_frame(8'd63, 0, 0);
      send_frame();
      build_frame(8'd64, 0, 0);
      send_frame();
      build_frame(8'd0, 2, 0);
      send_frame();

      // High extremes, and an empty type mask that refuses every type.
      settle();
      write_register(CSR_MAGIC, 64'hFFFF_FFFF);
      write_register(CSR_VERSION, 64'hFF);
      write_register(CSR_TYPE_MASK, 64'h0);
      build_frame(8'd0, 1, 0);
      send_frame();

      // Only the top type bit set.
      settle();
      write_register(CSR_TYPE_MASK, 64'h8000_0000_0000_0000);
      build_frame(8'd63, 1, 0);
      send_frame();
      build_frame(8'd62, 1, 0);
      send_frame();

      // Back to the reset values and one datagram that passes under them.
      settle();
      write_register(CSR_MAGIC, {32'h0, MAGIC_RESET});
      write_register(CSR_VERSION, {56'h0, VERSION_RESET});
      write_register(CSR_TYPE_MASK, TYPE_MASK_RESET);
      build_frame(pick_kind(), 8, 0);
      send_frame();

      // Hold the receiver off while single-byte datagrams keep coming, so that the
      // verdict queue fills and the byte input stalls. Then pause until all are out.
      wait_drained();
      hold_request = 1'b1;
      send_calm    = 1'b1;
      repeat (30) begin
         frame = {8'($urandom_range(255))};
         send_frame();
      end
      send_calm = 1'b0;
      wait_drained();

      // Random part: built datagrams, some damaged, and noise.
      random_start = bytes_offered;
      frames       = 0;
      while ((bytes_offered - random_start) < RANDOM_BYTES || frames < MIN_RANDOM_FRAMES) begin
         if (frames % 5 == 4) begin
            settle();
            retune();
         end
         send_calm = (frames >= 3 && frames < 9);
         recv_calm = send_calm;
         if ($urandom_range(99) < 70) begin
            build_frame(pick_kind(), $urandom_range(0, 24),
                        ($urandom_range(9) < 8) ? 0 : $urandom_range(1, 2));
            roll = $urandom_range(0, 2 * SPOIL_COUNT - 1);
            if (roll < SPOIL_COUNT) spoil_frame(spoil_type'(roll));
         end else begin
            noise_frame();
         end
         send_frame();
         frames++;
      end
      send_calm = 1'b0;
      recv_calm = 1'b0;

      stop_sending();
      waited = 0;
      while (board.pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending_verdicts.size() != 0) begin
         $display("%0d verdicts never arrived", board.pending_verdicts.size());
      end
      if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #(64'd20_000_000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/phc_pkg.sv
rtl/core/phc_if.sv
rtl/core/phc_csr.sv
rtl/core/phc_front.sv
rtl/core/phc_queue.sv
rtl/core/phc_back.sv
rtl/core/packet_header_checker.sv
tb/tb_packet_header_checker.sv
